@@ hw/rtl/lz77_greedy_matcher_macros.svh @@
// Assertion macros for the LZ77 greedy matcher; they expect clk and arst_n in scope.
`ifndef LZ77_GREEDY_MATCHER_MACROS_SVH
`define LZ77_GREEDY_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZGM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZGM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lzgm_pkg.sv @@
// Shared constants and types of the LZ77 greedy matcher.
package lzgm_pkg;

	localparam int WIN        = 32768;
	localparam int LA         = 258;
	localparam int RING_DEPTH = 65536;

	localparam int LA_USE  = (LA < RING_DEPTH) ? LA : RING_DEPTH;
	localparam int WIN_USE = (WIN < (RING_DEPTH - LA_USE)) ? WIN : (RING_DEPTH - LA_USE);

	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int LA_IW   = $clog2(LA_USE);
	localparam int CNT_W   = $clog2(WIN_USE + LA_USE);

	// field widths
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int LEN_W  = 9;
	localparam int DIST_W = 16;

	// match length tree: groups of GRP compare bits
	localparam int GRP    = 8;
	localparam int NG     = (LA_USE + GRP - 1) / GRP;
	localparam int GRP_CW = $clog2(GRP + 1);
	localparam int GI_W   = (NG > 1) ? $clog2(NG) : 1;

	localparam logic [LEN_W-1:0] LEN_FLOOR_RST = LEN_W'(3);

	localparam logic MODE_PUSH  = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	localparam logic [KIND_W-1:0] KIND_LIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// travels with one candidate window through the compare pipeline
	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] distance;
	} win_tag_t;

endpackage

@@ hw/rtl/lzgm_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
module lzgm_ram #(
	parameter int AW = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lzgm_match_len.sv @@
// Two-stage leading-ones count over the per-byte compare vector of one window.
module lzgm_match_len (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lzgm_pkg::LA_USE-1:0]      eq,
	input  lzgm_pkg::win_tag_t               tag_in,
	output logic [lzgm_pkg::LEN_W-1:0]       len,
	output lzgm_pkg::win_tag_t               tag_out
);

	logic [lzgm_pkg::NG*lzgm_pkg::GRP-1:0] eq_pad;
	logic [lzgm_pkg::NG-1:0]               grp_all_c;
	logic [lzgm_pkg::GRP_CW-1:0]           grp_cnt_c [lzgm_pkg::NG];

	logic [lzgm_pkg::NG-1:0]               grp_all_s2;
	logic [lzgm_pkg::GRP_CW-1:0]           grp_cnt_s2 [lzgm_pkg::NG];
	lzgm_pkg::win_tag_t                    tag_s2;

	logic [lzgm_pkg::GI_W-1:0]             first_c;
	logic [lzgm_pkg::LEN_W-1:0]            len_c;
	logic [lzgm_pkg::LEN_W-1:0]            len_s3;
	lzgm_pkg::win_tag_t                    tag_s3;

	// per group: all ones, and run of ones from the low end
	always_comb begin
		logic run;
		eq_pad = '0;
		eq_pad[lzgm_pkg::LA_USE-1:0] = eq;
		for (int g = 0; g < lzgm_pkg::NG; g++) begin
			run = 1'b1;
			grp_cnt_c[g] = '0;
			for (int b = 0; b < lzgm_pkg::GRP; b++) begin
				if (run && eq_pad[g*lzgm_pkg::GRP + b]) begin
					grp_cnt_c[g] = grp_cnt_c[g] + lzgm_pkg::GRP_CW'(1);
				end else begin
					run = 1'b0;
				end
			end
			grp_all_c[g] = &eq_pad[g*lzgm_pkg::GRP +: lzgm_pkg::GRP];
		end
	end

	always_ff @(posedge clk) begin
		grp_all_s2 <= grp_all_c;
		grp_cnt_s2 <= grp_cnt_c;
		len_s3     <= len_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2.vld      <= 1'b0;
			tag_s3.vld      <= 1'b0;
			tag_s2.distance <= '0;
			tag_s3.distance <= '0;
		end else begin
			tag_s2.vld      <= tag_in.vld;
			tag_s3.vld      <= tag_s2.vld;
			tag_s2.distance <= tag_in.distance;
			tag_s3.distance <= tag_s2.distance;
		end
	end

	// first group that is not all ones ends the run
	always_comb begin
		first_c = '0;
		for (int g = lzgm_pkg::NG - 1; g >= 0; g--) begin
			if (!grp_all_s2[g]) begin
				first_c = lzgm_pkg::GI_W'(g);
			end
		end
		if (&grp_all_s2) begin
			len_c = lzgm_pkg::LEN_W'(lzgm_pkg::LA_USE);
		end else begin
			len_c = lzgm_pkg::LEN_W'(int'(first_c) * lzgm_pkg::GRP)
				+ lzgm_pkg::LEN_W'(grp_cnt_s2[first_c]);
		end
	end

	assign len     = len_s3;
	assign tag_out = tag_s3;

endmodule

@@ hw/rtl/lz77_greedy_matcher.sv @@
// LZ77 greedy matcher: pushes are taken while idle; a token's search runs at one ring read a
// cycle: LA_USE reads load the lookahead, then a byte stream of fill + LA_USE - 1 reads
// slides the candidate window one position a cycle.
// One item at a time; a result waits in the output register while pushes go on.
// Async active-low reset clears pointers and counts; the ring is not cleared.
`include "lz77_greedy_matcher_macros.svh"

module lz77_greedy_matcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [lzgm_pkg::BYTE_W-1:0]     data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lzgm_pkg::KIND_W-1:0]     token_kind,
	output logic [lzgm_pkg::BYTE_W-1:0]     literal_value,
	output logic [lzgm_pkg::LEN_W-1:0]      match_length,
	output logic [lzgm_pkg::DIST_W-1:0]     match_distance,
	input  logic                            cfg_we,
	input  logic [lzgm_pkg::LEN_W-1:0]      cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DECIDE,
		ST_END
	} state_t;

	state_t                          state_q;
	logic [lzgm_pkg::LEN_W-1:0]      len_floor_q;
	logic [lzgm_pkg::RING_AW-1:0]    cur_q;
	logic [lzgm_pkg::DIST_W-1:0]     fill_q;
	logic [lzgm_pkg::LEN_W-1:0]      la_cnt_q;
	logic [lzgm_pkg::CNT_W-1:0]      rd_cnt_q;
	logic [lzgm_pkg::RING_AW-1:0]    rd_ptr_q;
	logic [lzgm_pkg::DIST_W-1:0]     d_q;
	logic [lzgm_pkg::LEN_W-1:0]      best_len_q;
	logic [lzgm_pkg::DIST_W-1:0]     best_dist_q;

	logic                            out_valid_q;
	logic [lzgm_pkg::KIND_W-1:0]     token_kind_q;
	logic [lzgm_pkg::BYTE_W-1:0]     literal_value_q;
	logic [lzgm_pkg::LEN_W-1:0]      match_length_q;
	logic [lzgm_pkg::DIST_W-1:0]     match_distance_q;

	// read pipeline
	logic                            rd_la_s1;
	logic                            rd_cand_s1;
	logic [lzgm_pkg::LA_IW-1:0]      la_idx_s1;
	logic [lzgm_pkg::LEN_W-1:0]      cand_n_q;
	logic                            win_vld_q;
	logic [lzgm_pkg::BYTE_W-1:0]     la_q   [lzgm_pkg::LA_USE];
	logic [lzgm_pkg::BYTE_W-1:0]     cand_q [lzgm_pkg::LA_USE];
	logic [lzgm_pkg::LA_USE-1:0]     eq_c;
	logic [lzgm_pkg::LA_USE-1:0]     eq_s1;
	lzgm_pkg::win_tag_t              tag_s1;

	logic [lzgm_pkg::LEN_W-1:0]      len_res;
	lzgm_pkg::win_tag_t              len_tag;

	logic                            in_fire;
	logic                            out_free;
	logic                            out_load;
	logic                            push_full;
	logic                            scan_issue;
	logic                            ram_we;
	logic [lzgm_pkg::RING_AW-1:0]    ram_waddr;
	logic [lzgm_pkg::RING_AW-1:0]    ram_raddr;
	logic [lzgm_pkg::BYTE_W-1:0]     ram_rdata;
	logic [lzgm_pkg::LEN_W-1:0]      step_c;
	logic [lzgm_pkg::DIST_W:0]       fill_sum_c;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = ((state_q == ST_DECIDE) || (state_q == ST_END)) && out_free;
	assign push_full = (la_cnt_q + lzgm_pkg::LEN_W'(1)) >= lzgm_pkg::LEN_W'(lzgm_pkg::LA_USE);

	assign scan_issue = (state_q == ST_SCAN) &&
		(rd_cnt_q < (lzgm_pkg::CNT_W'(fill_q) + lzgm_pkg::CNT_W'(lzgm_pkg::LA_USE - 1)));

	// writes only happen in idle, reads only outside it: no same-entry overlap
	assign ram_we    = in_fire && (mode == lzgm_pkg::MODE_PUSH);
	assign ram_waddr = cur_q + lzgm_pkg::RING_AW'(la_cnt_q);
	assign ram_raddr = (state_q == ST_LOAD) ? (cur_q + lzgm_pkg::RING_AW'(rd_cnt_q)) : rd_ptr_q;

	lzgm_ram #(
		.AW (lzgm_pkg::RING_AW),
		.DW (lzgm_pkg::BYTE_W)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign step_c     = (best_len_q == '0) ? lzgm_pkg::LEN_W'(1) : best_len_q;
	assign fill_sum_c = {1'b0, fill_q} + (lzgm_pkg::DIST_W + 1)'(step_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_floor_q <= lzgm_pkg::LEN_FLOOR_RST;
		end else if (cfg_we) begin
			len_floor_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			cur_q            <= '0;
			fill_q           <= '0;
			la_cnt_q         <= '0;
			rd_cnt_q         <= '0;
			rd_ptr_q         <= '0;
			d_q              <= '0;
			best_len_q       <= '0;
			best_dist_q      <= '0;
			out_valid_q      <= 1'b0;
			token_kind_q     <= lzgm_pkg::KIND_LIT;
			literal_value_q  <= '0;
			match_length_q   <= '0;
			match_distance_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (mode == lzgm_pkg::MODE_PUSH) begin
							la_cnt_q <= la_cnt_q + lzgm_pkg::LEN_W'(1);
							if (push_full) begin
								state_q     <= ST_LOAD;
								rd_cnt_q    <= '0;
								best_len_q  <= '0;
								best_dist_q <= '0;
							end
						end else if (la_cnt_q == '0) begin
							state_q <= ST_END;
						end else begin
							state_q     <= ST_LOAD;
							rd_cnt_q    <= '0;
							best_len_q  <= '0;
							best_dist_q <= '0;
						end
					end
				end
				ST_LOAD: begin
					rd_cnt_q <= rd_cnt_q + lzgm_pkg::CNT_W'(1);
					if (rd_cnt_q == lzgm_pkg::CNT_W'(lzgm_pkg::LA_USE - 1)) begin
						rd_cnt_q <= '0;
						rd_ptr_q <= cur_q - lzgm_pkg::RING_AW'(fill_q);
						d_q      <= fill_q;
						// first byte of a stream has nothing behind it
						state_q  <= (fill_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						rd_cnt_q <= rd_cnt_q + lzgm_pkg::CNT_W'(1);
						rd_ptr_q <= rd_ptr_q + lzgm_pkg::RING_AW'(1);
					end
					if (win_vld_q) begin
						d_q <= d_q - lzgm_pkg::DIST_W'(1);
					end
					if (len_tag.vld) begin
						// farthest first, so strict greater keeps the farthest on ties
						if (len_res >= len_floor_q && len_res > best_len_q) begin
							best_len_q  <= len_res;
							best_dist_q <= len_tag.distance;
						end
						if (len_tag.distance == lzgm_pkg::DIST_W'(1)) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (best_len_q == '0) begin
							token_kind_q     <= lzgm_pkg::KIND_LIT;
							literal_value_q  <= la_q[0];
							match_length_q   <= '0;
							match_distance_q <= '0;
						end else begin
							token_kind_q     <= lzgm_pkg::KIND_MATCH;
							literal_value_q  <= '0;
							match_length_q   <= best_len_q;
							match_distance_q <= best_dist_q;
						end
						cur_q    <= cur_q + lzgm_pkg::RING_AW'(step_c);
						la_cnt_q <= la_cnt_q - step_c;
						if (fill_sum_c > (lzgm_pkg::DIST_W + 1)'(lzgm_pkg::WIN_USE)) begin
							fill_q <= lzgm_pkg::DIST_W'(lzgm_pkg::WIN_USE);
						end else begin
							fill_q <= fill_sum_c[lzgm_pkg::DIST_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				ST_END: begin
					if (out_free) begin
						token_kind_q     <= lzgm_pkg::KIND_END;
						literal_value_q  <= '0;
						match_length_q   <= '0;
						match_distance_q <= '0;
						fill_q           <= '0;
						cur_q            <= '0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read data steering and window tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_la_s1        <= 1'b0;
			rd_cand_s1      <= 1'b0;
			cand_n_q        <= '0;
			win_vld_q       <= 1'b0;
			tag_s1.vld      <= 1'b0;
			tag_s1.distance <= '0;
		end else begin
			rd_la_s1   <= (state_q == ST_LOAD);
			rd_cand_s1 <= scan_issue;
			win_vld_q  <= rd_cand_s1 &&
				(cand_n_q >= lzgm_pkg::LEN_W'(lzgm_pkg::LA_USE - 1));
			if (state_q == ST_LOAD) begin
				cand_n_q <= '0;
			end else if (rd_cand_s1 && cand_n_q != lzgm_pkg::LEN_W'(lzgm_pkg::LA_USE)) begin
				cand_n_q <= cand_n_q + lzgm_pkg::LEN_W'(1);
			end
			tag_s1.vld      <= win_vld_q;
			tag_s1.distance <= d_q;
		end
	end

	always_comb begin
		for (int j = 0; j < lzgm_pkg::LA_USE; j++) begin
			eq_c[j] = (cand_q[j] == la_q[j]) && (lzgm_pkg::LEN_W'(j) < la_cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		la_idx_s1   <= rd_cnt_q[lzgm_pkg::LA_IW-1:0];
		eq_s1       <= eq_c;
		if (rd_la_s1) begin
			la_q[la_idx_s1] <= ram_rdata;
		end
		if (rd_cand_s1) begin
			for (int j = 0; j < lzgm_pkg::LA_USE - 1; j++) begin
				cand_q[j] <= cand_q[j+1];
			end
			cand_q[lzgm_pkg::LA_USE-1] <= ram_rdata;
		end
	end

	lzgm_match_len u_match_len (
		.clk     (clk),
		.arst_n  (arst_n),
		.eq      (eq_s1),
		.tag_in  (tag_s1),
		.len     (len_res),
		.tag_out (len_tag)
	);

	assign out_valid      = out_valid_q;
	assign token_kind     = token_kind_q;
	assign literal_value  = literal_value_q;
	assign match_length   = match_length_q;
	assign match_distance = match_distance_q;

	`LZGM_ASSERT_NOW(a_no_write_busy, (state_q != ST_IDLE), !ram_we, "ring written while busy")
	`LZGM_ASSERT_NOW(a_match_sane, (state_q == ST_DECIDE && best_len_q != '0), (best_len_q >= len_floor_q && best_len_q <= la_cnt_q && best_dist_q != '0 && best_dist_q <= fill_q), "selected match out of range")
	`LZGM_ASSERT_NOW(a_out_source, $rose(out_valid_q), ($past(state_q == ST_DECIDE) || $past(state_q == ST_END)), "result appeared outside decide or end")
	`LZGM_ASSERT_NEXT(a_last_window, (state_q == ST_SCAN && len_tag.vld && len_tag.distance == lzgm_pkg::DIST_W'(1)), (tag_s1.vld == 1'b0 && win_vld_q == 1'b0), "window still in flight after the nearest one")

endmodule
